// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error(msg);

// property holds on every cycle out of reset
`define ASSERT_ALWAYS(lbl, ck, rn, c, msg) \
  `ASSERT_IMPLIES(lbl, ck, rn, 1'b1, c, msg)

`endif

// ===== rtl/iidl_pkg.sv =====
`timescale 1ns / 1ps

package iidl_pkg;

  localparam int KIND_W = 3;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EDIT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic [CNT_W-1:0] MAX_RESET = 5'd16;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_APPEND,
    ACT_EDIT,
    ACT_READ,
    ACT_INIT,
    ACT_SH_RD,
    ACT_SH_WR,
    ACT_PUT,
    ACT_DEC,
    ACT_CAPTURE,
    ACT_EMIT
  } act_t;

  typedef struct packed {
    act_t act;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ok;
    logic              no_shift;
    logic              last;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/iidl_in_if.sv =====
`timescale 1ns / 1ps

interface iidl_in_if
  import iidl_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

// ===== rtl/iidl_out_if.sv =====
`timescale 1ns / 1ps

interface iidl_out_if
  import iidl_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [CNT_W-1:0]         entry_count;
  logic                     full_res;
  logic                     empty_res;
  logic [STAT_W-1:0]        status;

  modport source (output valid, read_value, entry_count, full_res, empty_res, status,
                  input ready);
  modport sink   (input valid, read_value, entry_count, full_res, empty_res, status,
                  output ready);
endinterface

// ===== rtl/iidl_ram.sv =====
`timescale 1ns / 1ps

module iidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/iidl_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iidl_dp
  import iidl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_read_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_full_res,
  output logic                     out_empty_res,
  output logic [STAT_W-1:0]        out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [CNT_W-1:0] CAP_LIM = (CAPACITY > 31) ? 5'd31 : CNT_W'(CAPACITY);

  function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] x);
    logic [XW-1:0] e;
    e = XW'(x);
    return e[AW-1:0];
  endfunction

  logic [CNT_W-1:0]         max_r, max_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [WORD_W-1:0] val_r, val_nxt;
  logic [STAT_W-1:0]        st_r, st_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [WORD_W-1:0] rv_r, rv_nxt;
  logic signed [WORD_W-1:0] ord_r, ord_nxt;
  logic [CNT_W-1:0]         ocnt_r, ocnt_nxt;
  logic                     ofull_r, ofull_nxt;
  logic                     oempty_r, oempty_nxt;
  logic [STAT_W-1:0]        ost_r, ost_nxt;

  logic [CNT_W-1:0]  lim;
  logic [STAT_W-1:0] ld_st;
  logic              is_ins;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  always_comb begin
    if (max_r == '0) begin
      lim = 5'd1;
    end else if (max_r > CAP_LIM) begin
      lim = CAP_LIM;
    end else begin
      lim = max_r;
    end
  end

  always_comb begin
    ld_st = ST_DONE;
    unique case (in_kind)
      KIND_APPEND: begin
        if (cnt_r >= lim) ld_st = ST_FULL;
      end
      KIND_INSERT: begin
        if (in_position > cnt_r) begin
          ld_st = ST_BAD_INDEX;
        end else if (cnt_r >= lim) begin
          ld_st = ST_FULL;
        end
      end
      KIND_DELETE, KIND_EDIT, KIND_READ: begin
        if (in_position >= cnt_r) ld_st = ST_BAD_INDEX;
      end
      default: ld_st = ST_DONE;
    endcase
  end

  assign is_ins = (kind_r == KIND_INSERT);

  assign sts.kind     = kind_r;
  assign sts.ok       = (st_r == ST_DONE);
  assign sts.no_shift = is_ins ? (pos_r == cnt_r)
                               : (({1'b0, pos_r} + 6'd1) == {1'b0, cnt_r});
  assign sts.last     = is_ins ? ((idx_r - 5'd1) == pos_r)
                               : (({1'b0, idx_r} + 6'd2) == {1'b0, cnt_r});
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    max_nxt       = max_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    rv_nxt        = rv_r;
    ord_nxt       = ord_r;
    ocnt_nxt      = ocnt_r;
    ofull_nxt     = ofull_r;
    oempty_nxt    = oempty_r;
    ost_nxt       = ost_r;
    ram_we        = 1'b0;
    ram_waddr     = to_addr(pos_r);
    ram_wdata     = val_r;
    ram_raddr     = to_addr(pos_r);

    if (cfg_we) max_nxt = cfg_wdata;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (cmd.act)
      ACT_NONE: begin
      end
      ACT_LOAD: begin
        kind_nxt = in_kind;
        pos_nxt  = in_position;
        val_nxt  = in_value;
        st_nxt   = ld_st;
        rv_nxt   = '0;
      end
      ACT_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = to_addr(cnt_r);
        cnt_nxt   = cnt_r + 5'd1;
      end
      ACT_EDIT: begin
        ram_we = 1'b1;
      end
      ACT_READ: begin
        ram_raddr = to_addr(pos_r);
      end
      ACT_INIT: begin
        idx_nxt = is_ins ? cnt_r : pos_r;
      end
      ACT_SH_RD: begin
        ram_raddr = is_ins ? to_addr(idx_r - 5'd1) : to_addr(idx_r + 5'd1);
      end
      ACT_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = to_addr(idx_r);
        ram_wdata = ram_rdata;
        if (is_ins) begin
          idx_nxt = idx_r - 5'd1;
        end else begin
          idx_nxt = idx_r + 5'd1;
          if (sts.last) cnt_nxt = cnt_r - 5'd1;
        end
      end
      ACT_PUT: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
      end
      ACT_DEC: begin
        cnt_nxt = cnt_r - 5'd1;
      end
      ACT_CAPTURE: begin
        rv_nxt = ram_rdata;
      end
      ACT_EMIT: begin
        ord_nxt       = rv_r;
        ocnt_nxt      = cnt_r;
        ofull_nxt     = (cnt_r >= lim);
        oempty_nxt    = (cnt_r == '0);
        ost_nxt       = st_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_r       <= max_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    st_r     <= st_nxt;
    idx_r    <= idx_nxt;
    rv_r     <= rv_nxt;
    ord_r    <= ord_nxt;
    ocnt_r   <= ocnt_nxt;
    ofull_r  <= ofull_nxt;
    oempty_r <= oempty_nxt;
    ost_r    <= ost_nxt;
  end

  iidl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_read_value  = ord_r;
  assign out_entry_count = ocnt_r;
  assign out_full_res    = ofull_r;
  assign out_empty_res   = oempty_r;
  assign out_status      = ost_r;

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CAP_LIM, "count beyond capacity")
  `ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.act == ACT_EMIT, !out_valid_r || out_ready, "result overwritten")
  `ASSERT_IMPLIES(a_grow_room, clk, rst_n, cmd.act == ACT_PUT || cmd.act == ACT_APPEND, cnt_r < lim, "grow on full list")
  `ASSERT_IMPLIES(a_dec_nonempty, clk, rst_n, cmd.act == ACT_DEC, cnt_r != '0, "shrink on empty list")

endmodule

// ===== rtl/iidl_ctrl.sv =====
`timescale 1ns / 1ps

module iidl_ctrl
  import iidl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd.act   = ACT_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.act   = ACT_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        if (sts.ok) begin
          unique case (sts.kind)
            KIND_APPEND: cmd.act = ACT_APPEND;
            KIND_INSERT: begin
              if (sts.no_shift) begin
                state_nxt = S_PUT;
              end else begin
                cmd.act   = ACT_INIT;
                state_nxt = S_SH_RD;
              end
            end
            KIND_DELETE: begin
              if (sts.no_shift) begin
                cmd.act = ACT_DEC;
              end else begin
                cmd.act   = ACT_INIT;
                state_nxt = S_SH_RD;
              end
            end
            KIND_EDIT: cmd.act = ACT_EDIT;
            KIND_READ: begin
              cmd.act   = ACT_READ;
              state_nxt = S_RD_WAIT;
            end
            default: cmd.act = ACT_NONE;
          endcase
        end
      end
      S_SH_RD: begin
        cmd.act   = ACT_SH_RD;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.act = ACT_SH_WR;
        if (!sts.last) begin
          state_nxt = S_SH_RD;
        end else if (sts.kind == KIND_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_PUT: begin
        cmd.act   = ACT_PUT;
        state_nxt = S_FINISH;
      end
      S_RD_WAIT: begin
        cmd.act   = ACT_CAPTURE;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.act   = ACT_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== rtl/indexed_insert_delete_list_top.sv =====
// channel | dir | payload                                             | transfer
// in_ch   | in  | kind, position, value                               | valid & ready
// out_ch  | out | read_value, entry_count, full_res, empty_res, status | valid & ready
// cfg     | in  | cfg_wdata (max_entries)                             | cfg_we
//
// One item at a time: load, decode, finish; finish emits once the output is free.
// Read adds a capture; insert/delete shift entries as read-write pairs, then insert puts.
// Entries sit in a RAM with registered read; each shift move is a read then a write.
// Reset (sync, rst_n low): count 0, limit 16; entries unset until written.
// A stalled result holds in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module indexed_insert_delete_list_top
  import iidl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  iidl_in_if.sink          in_ch,
  iidl_out_if.source       out_ch
);

  cmd_t cmd;
  sts_t sts;

  iidl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iidl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_value  (out_ch.read_value),
    .out_entry_count (out_ch.entry_count),
    .out_full_res    (out_ch.full_res),
    .out_empty_res   (out_ch.empty_res),
    .out_status      (out_ch.status)
  );

endmodule
